// ===== rtl/core/dns_query_message_builder_macros.svh =====
// Assertion macros shared by the DNS query message builder RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef DNS_QUERY_MESSAGE_BUILDER_MACROS_SVH
`define DNS_QUERY_MESSAGE_BUILDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DQMB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqmb: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DQMB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqmb: next-cycle check failed");

`endif

// ===== rtl/core/dqmb_pkg.sv =====
// Types and constants for the DNS query message builder.
// No dependencies; used by the controller, the datapath and the top level.
package dqmb_pkg;

  localparam int unsigned IDX_W       = 6;
  localparam int unsigned STORE_DEPTH = 64;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [IDX_W-1:0] HDR_ONE_IDX = 6'd5;
  localparam logic [IDX_W-1:0] HDR_LAST    = 6'd11;
  localparam logic [IDX_W-1:0] TRL_QT_IDX  = 6'd2;
  localparam logic [IDX_W-1:0] TRL_LAST    = 6'd4;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_CHAR    = 2'd1,
    CMD_END     = 2'd2,
    CMD_TRAILER = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_QTYPE,
    SRC_LEN,
    SRC_RAM
  } byte_src_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] char_byte;
    logic [7:0] query_type;
  } dqmb_query_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       label_error;
  } dqmb_msg_t;

  typedef struct packed {
    logic      emit;
    byte_src_t src;
    logic      last;
    logic      err;
    logic      cnt_inc;
    logic      cnt_clr;
    logic      len_inc;
    logic      len_clr;
    logic      ram_we;
    logic      qt_load;
  } dqmb_ctl_t;

  typedef struct packed {
    logic             out_free;
    logic             len_zero;
    logic             len_full;
    logic             data_last;
    logic [IDX_W-1:0] cnt;
  } dqmb_stat_t;

endpackage

// ===== rtl/core/dns_query_message_builder.sv =====
// Top level of the DNS query message builder: controller plus datapath.
// Depends on dqmb_pkg, dqmb_controller, dqmb_datapath.
//
//   channel  valid        stall        payload            dir
//   query    query_valid  query_stall  dqmb_query_t       in
//   msg      msg_valid    msg_stall    dqmb_msg_t         out
//
// Requests are taken one at a time, only while the controller is idle.
// A name character is written to the store; a dot or end of name with n pending
// characters emits a length byte, then one store read per byte.
// Start emits the header, trailer the trailer, a dropped character an error byte.
// Reset clears state, label length and output valid; the store needs no clearing.
// Output stall holds the output register and freezes the byte sequencer.
module dns_query_message_builder #(
  parameter int unsigned LABEL_MAX = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  query_valid,
  output logic                  query_stall,
  input  dqmb_pkg::dqmb_query_t query,
  output logic                  msg_valid,
  input  logic                  msg_stall,
  output dqmb_pkg::dqmb_msg_t   msg
);

  dqmb_pkg::dqmb_ctl_t  ctl;
  dqmb_pkg::dqmb_stat_t stat;

  dqmb_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .cmd         (query.cmd),
    .char_byte   (query.char_byte),
    .stat        (stat),
    .ctl         (ctl)
  );

  dqmb_datapath #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .char_byte  (query.char_byte),
    .query_type (query.query_type),
    .stat       (stat),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg)
  );

endmodule

// ===== rtl/core/dqmb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dqmb_datapath.sv =====
// Datapath: label store, label length, byte counter, query type and output register.
// Depends on dqmb_pkg and dqmb_ram.
module dqmb_datapath #(
  parameter int unsigned LABEL_MAX = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dqmb_pkg::dqmb_ctl_t  ctl,
  input  logic [7:0]           char_byte,
  input  logic [7:0]           query_type,
  output dqmb_pkg::dqmb_stat_t stat,
  output logic                 msg_valid,
  input  logic                 msg_stall,
  output dqmb_pkg::dqmb_msg_t  msg
);

  localparam logic [dqmb_pkg::IDX_W-1:0] LEN_MAX = dqmb_pkg::IDX_W'(LABEL_MAX);

  logic [dqmb_pkg::IDX_W-1:0] len;
  logic [dqmb_pkg::IDX_W-1:0] cnt;
  logic [dqmb_pkg::IDX_W-1:0] cnt_next;
  logic [dqmb_pkg::IDX_W-1:0] cnt_plus;
  logic [7:0]                 qtype;
  logic [7:0]                 rd_byte;
  logic [7:0]                 byte_next;

  assign cnt_plus = cnt + dqmb_pkg::IDX_W'(1);

  always_comb begin
    if (ctl.cnt_clr) begin
      cnt_next = '0;
    end else if (ctl.cnt_inc) begin
      cnt_next = cnt_plus;
    end else begin
      cnt_next = cnt;
    end
  end

  // read address follows the next count so data is ready when the counter lands
  dqmb_ram #(
    .WIDTH (8),
    .DEPTH (dqmb_pkg::STORE_DEPTH)
  ) u_label_store (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (len),
    .wdata (char_byte),
    .raddr (cnt_next),
    .rdata (rd_byte)
  );

  always_comb begin
    case (ctl.src)
      dqmb_pkg::SRC_ZERO:  byte_next = 8'h00;
      dqmb_pkg::SRC_ONE:   byte_next = 8'h01;
      dqmb_pkg::SRC_QTYPE: byte_next = qtype;
      dqmb_pkg::SRC_LEN:   byte_next = {{(8 - dqmb_pkg::IDX_W){1'b0}}, len};
      dqmb_pkg::SRC_RAM:   byte_next = rd_byte;
      default:             byte_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      cnt       <= '0;
      msg_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      msg_valid <= ctl.emit | (msg_valid & msg_stall);
      if (ctl.len_clr) begin
        len <= '0;
      end else if (ctl.len_inc) begin
        len <= len + dqmb_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      msg.out_byte    <= byte_next;
      msg.run_last    <= ctl.last;
      msg.label_error <= ctl.err;
    end
    if (ctl.qt_load) begin
      qtype <= query_type;
    end
  end

  assign stat.out_free  = ~msg_valid | ~msg_stall;
  assign stat.len_zero  = (len == '0);
  assign stat.len_full  = (len >= LEN_MAX);
  assign stat.data_last = (cnt_plus == len);
  assign stat.cnt       = cnt;

endmodule

// ===== rtl/core/dqmb_controller.sv =====
// Controller: sequences header, label, error and trailer bytes.
// Depends on dqmb_pkg and dns_query_message_builder_macros.svh.
`include "dns_query_message_builder_macros.svh"

module dqmb_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 query_valid,
  output logic                 query_stall,
  input  dqmb_pkg::cmd_t       cmd,
  input  logic [7:0]           char_byte,
  input  dqmb_pkg::dqmb_stat_t stat,
  output dqmb_pkg::dqmb_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEADER,
    S_TRAILER,
    S_LEN,
    S_DATA,
    S_ERR
  } state_t;

  state_t state;
  state_t state_next;

  assign query_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.src    = dqmb_pkg::SRC_ZERO;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_valid) begin
          case (cmd)
            dqmb_pkg::CMD_START: begin
              ctl.len_clr = 1'b1;
              ctl.cnt_clr = 1'b1;
              state_next  = S_HEADER;
            end
            dqmb_pkg::CMD_CHAR: begin
              if (char_byte == dqmb_pkg::DOT_CHAR) begin
                ctl.cnt_clr = 1'b1;
                state_next  = S_LEN;
              end else if (stat.len_full) begin
                state_next = S_ERR;
              end else begin
                ctl.ram_we  = 1'b1;
                ctl.len_inc = 1'b1;
              end
            end
            dqmb_pkg::CMD_END: begin
              if (!stat.len_zero) begin
                ctl.cnt_clr = 1'b1;
                state_next  = S_LEN;
              end
            end
            dqmb_pkg::CMD_TRAILER: begin
              ctl.len_clr = 1'b1;
              ctl.cnt_clr = 1'b1;
              ctl.qt_load = 1'b1;
              state_next  = S_TRAILER;
            end
            default: begin
            end
          endcase
        end
      end
      S_HEADER: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          ctl.src  = (stat.cnt == dqmb_pkg::HDR_ONE_IDX) ? dqmb_pkg::SRC_ONE
                                                          : dqmb_pkg::SRC_ZERO;
          if (stat.cnt == dqmb_pkg::HDR_LAST) begin
            ctl.last    = 1'b1;
            ctl.cnt_clr = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ctl.cnt_inc = 1'b1;
          end
        end
      end
      S_TRAILER: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          if (stat.cnt == dqmb_pkg::TRL_QT_IDX) begin
            ctl.src = dqmb_pkg::SRC_QTYPE;
          end else if (stat.cnt == dqmb_pkg::TRL_LAST) begin
            ctl.src = dqmb_pkg::SRC_ONE;
          end
          if (stat.cnt == dqmb_pkg::TRL_LAST) begin
            ctl.last    = 1'b1;
            ctl.cnt_clr = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ctl.cnt_inc = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          ctl.src  = dqmb_pkg::SRC_LEN;
          if (stat.len_zero) begin
            ctl.last    = 1'b1;
            ctl.len_clr = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          ctl.src  = dqmb_pkg::SRC_RAM;
          if (stat.data_last) begin
            ctl.last    = 1'b1;
            ctl.cnt_clr = 1'b1;
            ctl.len_clr = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ctl.cnt_inc = 1'b1;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          ctl.err    = 1'b1;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DQMB_ASSERT_IMPL(a_emit_needs_room, ctl.emit, stat.out_free)
  `DQMB_ASSERT_IMPL(a_err_is_last, ctl.emit && ctl.err, ctl.last)
  `DQMB_ASSERT_IMPL(a_write_below_max, ctl.ram_we, !stat.len_full && (state == S_IDLE))
  `DQMB_ASSERT_NEXT(a_label_runs_out, (state == S_DATA) && !(ctl.emit && ctl.last), state == S_DATA)

endmodule
